### rtl/core/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and codes for the button click/hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

	localparam int TICK_W    = 8;
	localparam int THR_W     = 16;
	localparam int CLICK_W   = 4;
	localparam int EVENT_W   = 2;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX     = 8'd3;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd10;
	localparam logic [THR_W-1:0]  CLICK_MIN_RST   = 16'd30;
	localparam logic [THR_W-1:0]  HOLD_MIN_RST    = 16'd800;
	localparam logic [THR_W-1:0]  GAP_MAX_RST     = 16'd250;

	localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE  = 2'd0,
		EV_PRESS = 2'd1,
		EV_HOLD  = 2'd2,
		EV_MULTI = 2'd3
	} event_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_period;
		logic [THR_W-1:0]  click_min_ms;
		logic [THR_W-1:0]  hold_min_ms;
		logic [THR_W-1:0]  gap_max_ms;
	} cfg_t;

	typedef struct packed {
		event_t             ev;
		logic [CLICK_W-1:0] clicks;
	} result_t;

endpackage

### rtl/core/bchd_fsm.sv
// ----------------------------------------------------------------------------
// bchd_fsm
// Key state machine with press/gap accumulators and click counter; advances
// one scan tick per request.
// ----------------------------------------------------------------------------
module bchd_fsm
	import bchd_pkg::*;
#(
	parameter int TIME_WIDTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    key_pressed,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int SUM_W = TIME_WIDTH + 1;
	localparam int CMP_W = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;

	typedef enum logic [2:0] {
		ST_RELEASE  = 3'd0,
		ST_DITHER   = 3'd1,
		ST_PRECLICK = 3'd2,
		ST_INCLICK  = 3'd3,
		ST_PRESS    = 3'd4,
		ST_HOLD     = 3'd5,
		ST_MULTI    = 3'd6
	} state_t;

	state_t                  state_q, state_d;
	logic [TIME_WIDTH-1:0]   pressed_q, pressed_d, pressed_base;
	logic [TIME_WIDTH-1:0]   gap_q, gap_d;
	logic [CLICK_W-1:0]      clicks_q, clicks_d, clicks_inc;
	logic [SUM_W-1:0]        tick_ext, pressed_sum, gap_sum;
	logic [CMP_W-1:0]        pt_c, gap_c, press_thr_c, hold_thr_c, intv_thr_c;
	event_t                  ev;

	always_comb begin
		tick_ext = SUM_W'(cfg.tick_period);

		// pressed time survives a release only in dither and hold
		if (!key_pressed && state_q != ST_DITHER && state_q != ST_HOLD)
			pressed_base = '0;
		else
			pressed_base = pressed_q;

		pressed_sum = {1'b0, pressed_base} + tick_ext;
		if (!key_pressed)
			pressed_d = pressed_base;
		else if (pressed_sum[TIME_WIDTH])
			pressed_d = '1;
		else
			pressed_d = pressed_sum[TIME_WIDTH-1:0];

		gap_sum = {1'b0, gap_q} + tick_ext;
		if (state_q == ST_PRECLICK || state_q == ST_INCLICK)
			gap_d = gap_sum[TIME_WIDTH] ? '1 : gap_sum[TIME_WIDTH-1:0];
		else
			gap_d = '0;

		pt_c        = CMP_W'(pressed_d);
		gap_c       = CMP_W'(gap_d);
		press_thr_c = CMP_W'(cfg.click_min_ms);
		hold_thr_c  = CMP_W'(cfg.hold_min_ms);
		intv_thr_c  = CMP_W'(cfg.gap_max_ms);

		clicks_inc = (clicks_q == CLICK_MAX) ? clicks_q : clicks_q + 1'b1;

		state_d  = state_q;
		clicks_d = clicks_q;
		ev       = EV_NONE;

		case (state_q)
			ST_RELEASE: begin
				clicks_d = '0;
				if (key_pressed)
					state_d = ST_DITHER;
			end
			ST_DITHER: begin
				if (pt_c > hold_thr_c)
					state_d = ST_HOLD;
				if (!key_pressed) begin
					if (pt_c > press_thr_c && pt_c < hold_thr_c) begin
						state_d  = ST_PRECLICK;
						clicks_d = clicks_inc;
					end else begin
						state_d = ST_RELEASE;
					end
				end
			end
			ST_PRECLICK: begin
				if (gap_c < intv_thr_c) begin
					if (pt_c > press_thr_c) begin
						state_d  = ST_MULTI;
						clicks_d = clicks_inc;
					end
				end else begin
					state_d = ST_PRESS;
				end
			end
			ST_INCLICK: begin
				if (gap_c < intv_thr_c) begin
					if (pt_c > press_thr_c) begin
						state_d  = ST_MULTI;
						clicks_d = clicks_inc;
					end
				end else begin
					ev      = EV_MULTI;
					state_d = ST_RELEASE;
				end
			end
			ST_PRESS: begin
				ev = EV_PRESS;
				if (!key_pressed)
					state_d = ST_RELEASE;
			end
			ST_HOLD: begin
				if (!key_pressed) begin
					ev      = EV_HOLD;
					state_d = ST_RELEASE;
				end
			end
			ST_MULTI: begin
				if (!key_pressed)
					state_d = ST_INCLICK;
			end
			default: begin
				// unused code behaves as release
				clicks_d = '0;
				state_d  = key_pressed ? ST_DITHER : ST_RELEASE;
			end
		endcase

		res.ev     = ev;
		res.clicks = clicks_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RELEASE;
			pressed_q <= '0;
			gap_q     <= '0;
			clicks_q  <= '0;
		end else if (step) begin
			state_q   <= state_d;
			pressed_q <= pressed_d;
			gap_q     <= gap_d;
			clicks_q  <= clicks_d;
		end
	end

endmodule

### rtl/core/button_click_hold_detector_core.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector_core
// Debounce, multi-click and long-press detection for one push button.
// ----------------------------------------------------------------------------
// Each input request is one scan tick carrying the sampled key level; each
// tick produces exactly one result (event code and current click count). The
// state update is combinational logic into the state registers and the result
// lands in an output register, so one tick is accepted per clock unless held
// off, and the result appears in the cycle after acceptance. The input is
// held off only while a result waits in the output register and the output
// is stalled. Config writes are always accepted; indexes above 3 are dropped.
// ----------------------------------------------------------------------------
module button_click_hold_detector_core
	import bchd_pkg::*;
#(
	parameter int TIME_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 key_pressed,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [EVENT_W-1:0]   event_res,
	output logic [CLICK_W-1:0]   click_count
);

	cfg_t               cfg_q;
	result_t            res;
	logic               in_fire;
	logic               out_valid_q;
	logic [EVENT_W-1:0] event_q;
	logic [CLICK_W-1:0] clicks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period  <= TICK_PERIOD_RST;
			cfg_q.click_min_ms <= CLICK_MIN_RST;
			cfg_q.hold_min_ms  <= HOLD_MIN_RST;
			cfg_q.gap_max_ms   <= GAP_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TICK_PERIOD: cfg_q.tick_period  <= cfg_data[TICK_W-1:0];
				REG_CLICK_MIN:   cfg_q.click_min_ms <= cfg_data;
				REG_HOLD_MIN:    cfg_q.hold_min_ms  <= cfg_data;
				REG_GAP_MAX:     cfg_q.gap_max_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	bchd_fsm #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_fire),
		.key_pressed (key_pressed),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			event_q  <= res.ev;
			clicks_q <= res.clicks;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = event_q;
	assign click_count = clicks_q;

endmodule
